[design/arcmm_pkg.sv]
// constants, types and register codes for the attitude rate control motor mixer
// no dependencies; used by attitude_rate_control_motor_mixer_core
package arcmm_pkg;

	localparam int NUM_MOTORS = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// fixed point alignment
	localparam int QUAT_SHIFT  = 6;   // Q.22 quaternion term down to Q.16
	localparam int QUAD_ALIGN  = 15;  // quad mix Q.16 up to the hex Q.31 grid
	localparam int HEX_HALF_SH = 14;  // 0.5 in Q1.15 is a shift by 14
	localparam int FRAC_BITS   = 39;  // fraction bits after pwm scaling
	localparam int LO_SPLIT    = 24;  // low part width of the split scaling multiply

	// hex mixer constants, Q1.15
	localparam logic signed [14:0] HEX_C134  = 15'sd4391;
	localparam logic signed [14:0] HEX_C2679 = 15'sd8779;
	localparam logic signed [14:0] HEX_C2321 = 15'sd7605;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUAT_GAIN_XY = 3'd0,
		REG_RATE_GAIN_XY = 3'd1,
		REG_RATE_GAIN_Z  = 3'd2,
		REG_PWM_SCALING  = 3'd3,
		REG_CLIP_LOW     = 3'd4,
		REG_CLIP_HIGH    = 3'd5,
		REG_FRAME_MODE   = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		FRAME_QUAD = 1'b0,
		FRAME_HEX  = 1'b1
	} frame_t;

	// motor lane order
	localparam int M_FL = 0;
	localparam int M_FR = 1;
	localparam int M_BL = 2;
	localparam int M_BR = 3;
	localparam int M_ML = 4;
	localparam int M_MR = 5;

	typedef logic signed [48:0] mix_t;
	typedef logic signed [66:0] acc_t;

	typedef struct packed {
		logic signed [31:0] roll;
		logic signed [31:0] pitch;
		logic signed [31:0] yaw;
	} cmd_t;

	typedef struct packed {
		logic [15:0] thr;
		frame_t      mode;
	} side_t;

endpackage

[design/attitude_rate_control_motor_mixer_core.sv]
// attitude rate control with quad or hex motor mixing, seven stage pipeline
// depends on arcmm_pkg
//
// usage
//   request channel: a request (attitude error x/y, body rates, yaw rate
//   reference, throttle) is taken at a rising edge with start high and busy low.
//   busy is held low: the pipeline takes one request every cycle.
//   result channel: done is high for exactly one cycle with all six motor
//   values and the roll, pitch and yaw commands; the result is taken at the
//   edge that ends that cycle. the receiver cannot hold results off, and the
//   pipeline never needs to stall.
//   throughput: one request per cycle; every stage is registered and nothing
//   feeds back, the wide scaling multiply is split into two partial products.
//   configuration: cfg_we writes cfg_wdata into register cfg_idx at the edge;
//   unknown indexes are dropped. the user must change registers only while
//   idle; the block itself does not enforce it.
//   reset: arst_n low clears all valid bits and loads the register defaults
//   (gains 0, scaling 1.0, clip 0..65535, quad frame); nothing is in flight.
module attitude_rate_control_motor_mixer_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [arcmm_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [arcmm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// request
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [15:0]                   att_err_x,
	input  logic signed [15:0]                   att_err_y,
	input  logic signed [15:0]                   rate_x,
	input  logic signed [15:0]                   rate_y,
	input  logic signed [15:0]                   rate_z,
	input  logic signed [15:0]                   yaw_rate_ref,
	input  logic [15:0]                          throttle,
	// result
	output logic                                 done,
	output logic [15:0]                          motor_front_left,
	output logic [15:0]                          motor_front_right,
	output logic [15:0]                          motor_back_left,
	output logic [15:0]                          motor_back_right,
	output logic [15:0]                          motor_mid_left,
	output logic [15:0]                          motor_mid_right,
	output logic signed [31:0]                   roll_command,
	output logic signed [31:0]                   pitch_command,
	output logic signed [31:0]                   yaw_command
);

	// configuration registers
	logic signed [15:0] quat_gain_xy_q;
	logic signed [15:0] rate_gain_xy_q;
	logic signed [15:0] rate_gain_z_q;
	logic [15:0]        pwm_scaling_q;
	logic [15:0]        clip_low_q;
	logic [15:0]        clip_high_q;
	arcmm_pkg::frame_t  frame_mode_q;

	// valid bits, one per stage
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// stage 1: gain products
	logic signed [31:0] pqx_s1, pqy_s1, prx_s1, pry_s1;
	logic signed [32:0] pyz_s1;
	arcmm_pkg::side_t   side_s1;

	// stage 2: roll, pitch, yaw commands
	arcmm_pkg::cmd_t    cmd_s2;
	arcmm_pkg::side_t   side_s2;

	// stage 3: quad sums and hex constant products
	logic signed [33:0] quad_s3 [4];
	logic signed [47:0] side_mul_s3;
	logic signed [46:0] mid_a_s3, mid_b_s3;
	arcmm_pkg::cmd_t    cmd_s3;
	arcmm_pkg::side_t   side_s3;

	// stage 4: per motor mix on the Q.31 grid
	arcmm_pkg::mix_t    mix_s4 [arcmm_pkg::NUM_MOTORS];
	arcmm_pkg::cmd_t    cmd_s4;
	arcmm_pkg::side_t   side_s4;

	// stage 5: scaling partial products
	logic [39:0]        plo_s5 [arcmm_pkg::NUM_MOTORS];
	logic signed [41:0] phi_s5 [arcmm_pkg::NUM_MOTORS];
	arcmm_pkg::cmd_t    cmd_s5;
	arcmm_pkg::side_t   side_s5;

	// stage 6: throttle plus scaled mix
	arcmm_pkg::acc_t    acc_s6 [arcmm_pkg::NUM_MOTORS];
	arcmm_pkg::cmd_t    cmd_s6;
	arcmm_pkg::side_t   side_s6;

	// stage 7: clamped motor values, output register
	logic [15:0]        motor_s7 [arcmm_pkg::NUM_MOTORS];
	arcmm_pkg::cmd_t    cmd_s7;
	arcmm_pkg::side_t   side_s7;

	logic               accept;
	logic signed [16:0] yaw_err;
	logic signed [32:0] roll_yaw;
	logic signed [45:0] half_p;
	arcmm_pkg::mix_t    hp, sd, md;
	arcmm_pkg::mix_t    mix_next [arcmm_pkg::NUM_MOTORS];
	logic [15:0]        motor_next [arcmm_pkg::NUM_MOTORS];

	// every request is taken; no stage ever waits
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_gain_xy_q <= '0;
			rate_gain_xy_q <= '0;
			rate_gain_z_q  <= '0;
			pwm_scaling_q  <= 16'd256;
			clip_low_q     <= '0;
			clip_high_q    <= 16'hffff;
			frame_mode_q   <= arcmm_pkg::FRAME_QUAD;
		end else if (cfg_we) begin
			case (cfg_idx)
				arcmm_pkg::REG_QUAT_GAIN_XY: quat_gain_xy_q <= $signed(cfg_wdata);
				arcmm_pkg::REG_RATE_GAIN_XY: rate_gain_xy_q <= $signed(cfg_wdata);
				arcmm_pkg::REG_RATE_GAIN_Z:  rate_gain_z_q  <= $signed(cfg_wdata);
				arcmm_pkg::REG_PWM_SCALING:  pwm_scaling_q  <= cfg_wdata;
				arcmm_pkg::REG_CLIP_LOW:     clip_low_q     <= cfg_wdata;
				arcmm_pkg::REG_CLIP_HIGH:    clip_high_q    <= cfg_wdata;
				arcmm_pkg::REG_FRAME_MODE:   frame_mode_q   <= arcmm_pkg::frame_t'(cfg_wdata[0]);
				default: ;
			endcase
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// yaw rate error and hex intermediate terms
	always_comb begin
		yaw_err  = 17'(rate_z) - 17'(yaw_rate_ref);
		roll_yaw = 33'(cmd_s2.roll) + 33'(cmd_s2.yaw);
		half_p   = $signed({cmd_s3.pitch, {arcmm_pkg::HEX_HALF_SH{1'b0}}});
		hp       = 49'(half_p);
		sd       = 49'(side_mul_s3);
		md       = 49'(mid_a_s3) - 49'(mid_b_s3);
		if (side_s3.mode == arcmm_pkg::FRAME_HEX) begin
			mix_next[arcmm_pkg::M_FL] = hp + sd;
			mix_next[arcmm_pkg::M_FR] = hp - sd;
			mix_next[arcmm_pkg::M_BL] = sd - hp;
			mix_next[arcmm_pkg::M_BR] = -hp - sd;
			mix_next[arcmm_pkg::M_ML] = md;
			mix_next[arcmm_pkg::M_MR] = -md;
		end else begin
			// quad mix moved onto the hex fraction grid
			mix_next[arcmm_pkg::M_FL] = 49'(quad_s3[0]) <<< arcmm_pkg::QUAD_ALIGN;
			mix_next[arcmm_pkg::M_FR] = 49'(quad_s3[1]) <<< arcmm_pkg::QUAD_ALIGN;
			mix_next[arcmm_pkg::M_BL] = 49'(quad_s3[2]) <<< arcmm_pkg::QUAD_ALIGN;
			mix_next[arcmm_pkg::M_BR] = 49'(quad_s3[3]) <<< arcmm_pkg::QUAD_ALIGN;
			mix_next[arcmm_pkg::M_ML] = '0;
			mix_next[arcmm_pkg::M_MR] = '0;
		end
	end

	// truncate toward zero then clamp; a negative sum always ends at clip_low,
	// so only the non-negative integer part needs a compare
	always_comb begin
		logic        neg;
		logic [26:0] ip;
		logic [15:0] lim;
		for (int i = 0; i < arcmm_pkg::NUM_MOTORS; i++) begin
			neg = acc_s6[i][66];
			ip  = acc_s6[i][65:arcmm_pkg::FRAC_BITS];
			lim = (ip > 27'(clip_high_q)) ? clip_high_q : ip[15:0];
			motor_next[i] = (neg || (lim < clip_low_q)) ? clip_low_q : lim;
		end
		// quad frame has no middle motors
		if (side_s6.mode == arcmm_pkg::FRAME_QUAD) begin
			motor_next[arcmm_pkg::M_ML] = '0;
			motor_next[arcmm_pkg::M_MR] = '0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// stage 1: four gain products and the yaw error product
		pqx_s1       <= quat_gain_xy_q * att_err_x;
		pqy_s1       <= quat_gain_xy_q * att_err_y;
		prx_s1       <= rate_gain_xy_q * rate_x;
		pry_s1       <= rate_gain_xy_q * rate_y;
		pyz_s1       <= rate_gain_z_q * yaw_err;
		side_s1.thr  <= throttle;
		side_s1.mode <= frame_mode_q;

		// stage 2: quaternion term floors to Q.16, sums fit in 32 bits
		cmd_s2.roll  <= (pqx_s1 >>> arcmm_pkg::QUAT_SHIFT) + prx_s1;
		cmd_s2.pitch <= (pqy_s1 >>> arcmm_pkg::QUAT_SHIFT) + pry_s1;
		cmd_s2.yaw   <= pyz_s1[31:0];
		side_s2      <= side_s1;

		// stage 3
		quad_s3[0]  <= 34'(cmd_s2.roll) + 34'(cmd_s2.pitch) + 34'(cmd_s2.yaw);
		quad_s3[1]  <= 34'(cmd_s2.pitch) - 34'(cmd_s2.roll) - 34'(cmd_s2.yaw);
		quad_s3[2]  <= 34'(cmd_s2.roll) - 34'(cmd_s2.pitch) - 34'(cmd_s2.yaw);
		quad_s3[3]  <= 34'(cmd_s2.yaw) - 34'(cmd_s2.roll) - 34'(cmd_s2.pitch);
		side_mul_s3 <= arcmm_pkg::HEX_C134 * roll_yaw;
		mid_a_s3    <= arcmm_pkg::HEX_C2679 * cmd_s2.roll;
		mid_b_s3    <= arcmm_pkg::HEX_C2321 * cmd_s2.yaw;
		cmd_s3      <= cmd_s2;
		side_s3     <= side_s2;

		// stage 4
		for (int i = 0; i < arcmm_pkg::NUM_MOTORS; i++) begin
			mix_s4[i] <= mix_next[i];
		end
		cmd_s4  <= cmd_s3;
		side_s4 <= side_s3;

		// stage 5: mix times scaling as low and high partial products
		for (int i = 0; i < arcmm_pkg::NUM_MOTORS; i++) begin
			plo_s5[i] <= 40'(mix_s4[i][arcmm_pkg::LO_SPLIT-1:0]) * 40'(pwm_scaling_q);
			phi_s5[i] <= $signed(mix_s4[i][48:arcmm_pkg::LO_SPLIT])
				* $signed({1'b0, pwm_scaling_q});
		end
		cmd_s5  <= cmd_s4;
		side_s5 <= side_s4;

		// stage 6: recombine and add throttle on the same grid
		for (int i = 0; i < arcmm_pkg::NUM_MOTORS; i++) begin
			acc_s6[i] <= (67'(phi_s5[i]) <<< arcmm_pkg::LO_SPLIT)
				+ 67'($signed({1'b0, plo_s5[i]}))
				+ 67'($signed({1'b0, side_s5.thr, {arcmm_pkg::FRAC_BITS{1'b0}}}));
		end
		cmd_s6  <= cmd_s5;
		side_s6 <= side_s5;

		// stage 7: clamp into the output register
		for (int i = 0; i < arcmm_pkg::NUM_MOTORS; i++) begin
			motor_s7[i] <= motor_next[i];
		end
		cmd_s7  <= cmd_s6;
		side_s7 <= side_s6;
	end

	// result ports
	assign done              = v_s7;
	assign motor_front_left  = motor_s7[arcmm_pkg::M_FL];
	assign motor_front_right = motor_s7[arcmm_pkg::M_FR];
	assign motor_back_left   = motor_s7[arcmm_pkg::M_BL];
	assign motor_back_right  = motor_s7[arcmm_pkg::M_BR];
	assign motor_mid_left    = motor_s7[arcmm_pkg::M_ML];
	assign motor_mid_right   = motor_s7[arcmm_pkg::M_MR];
	assign roll_command      = cmd_s7.roll;
	assign pitch_command     = cmd_s7.pitch;
	assign yaw_command       = cmd_s7.yaw;

	// every result stems from an accepted request
	a_done_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 7))
		else $error("result without matching request");

	// with ordered clip limits in hex frame, front left and mid right lie inside them
	a_motor_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(done && side_s7.mode == arcmm_pkg::FRAME_HEX
		&& $past(clip_low_q) <= $past(clip_high_q))
		|-> (motor_front_left >= $past(clip_low_q) && motor_front_left <= $past(clip_high_q)
		&& motor_mid_right >= $past(clip_low_q) && motor_mid_right <= $past(clip_high_q)))
		else $error("motor value outside clip limits");

	// quad frame leaves the middle motors at zero
	a_quad_mid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && side_s7.mode == arcmm_pkg::FRAME_QUAD)
		|-> (motor_mid_left == 16'd0 && motor_mid_right == 16'd0))
		else $error("middle motor driven in quad frame");

endmodule

[dv/attitude_rate_control_motor_mixer_core_tb.sv]
// self-checking testbench for attitude_rate_control_motor_mixer_core
// depends on arcmm_pkg and the core; predicts roll, pitch, yaw commands and motor pwm
// values for untyped rows of a directed table and then for random settings
module attitude_rate_control_motor_mixer_core_tb;
	import arcmm_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_ITEMS = 1700;
	localparam int PIPE_DEPTH = 7;
	localparam int MAX_REPORTS = 10;
	localparam int IDLE_PCT = 28;
	localparam int DIR_ROWS = 21;
	localparam int DIR_SETS = 6;

	// fixed point alignment of the mixer
	localparam int Q22_TO_Q16 = 6;   // quaternion term, floor
	localparam int QUAD_FRAC = 24;   // Q.16 mix times Q8.8 scaling
	localparam int HEX_FRAC = 39;    // Q.31 mix times Q8.8 scaling

	// hex mixer weights in Q1.15
	localparam longint K_HALF = 16384;
	localparam longint K_134 = 4391;
	localparam longint K_2679 = 8779;
	localparam longint K_2321 = 7605;

	// the one index the register file does not decode
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [15:0] att_err_x;
		logic [15:0] att_err_y;
		logic [15:0] rate_x;
		logic [15:0] rate_y;
		logic [15:0] rate_z;
		logic [15:0] yaw_rate_ref;
		logic [15:0] throttle;
	} sample_t;

	typedef struct packed {
		logic [NUM_MOTORS-1:0][15:0] pwm;
		logic [31:0] roll;
		logic [31:0] pitch;
		logic [31:0] yaw;
	} mix_out_t;

	typedef struct packed {
		logic [15:0] quat_gain;
		logic [15:0] rate_gain;
		logic [15:0] yaw_gain;
		logic [15:0] scaling;
		logic [15:0] clip_lo;
		logic [15:0] clip_hi;
		frame_t      mode;
	} setting_t;

	// one row of the directed table; typed rows carry an expectation read off by hand
	typedef struct packed {
		logic [2:0] set_id;
		logic       typed;
		sample_t    s;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic start;
	logic busy;
	logic done;
	logic [15:0] motor_front_left;
	logic [15:0] motor_front_right;
	logic [15:0] motor_back_left;
	logic [15:0] motor_back_right;
	logic [15:0] motor_mid_left;
	logic [15:0] motor_mid_right;
	logic signed [31:0] roll_command;
	logic signed [31:0] pitch_command;
	logic signed [31:0] yaw_command;

	// request as driven on the ports, plus a hand-typed expectation where there is one
	sample_t req_drive;
	logic req_typed;
	mix_out_t req_expect;

	// shadow of the register file, updated at the same edge as the block's
	setting_t m_set;

	// expected results in request order
	mix_out_t mix_expect_q [$];

	int cycle_cnt = 0;
	int req_cnt = 0;
	int res_cnt = 0;
	int err_cnt = 0;
	int setting_cnt = 0;
	int idle_pct = IDLE_PCT;

	setting_t dir_set [DIR_SETS];
	dir_row_t dir_tab [DIR_ROWS];

	attitude_rate_control_motor_mixer_core u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_idx           (cfg_idx),
		.cfg_wdata         (cfg_wdata),
		.start             (start),
		.busy              (busy),
		.att_err_x         (req_drive.att_err_x),
		.att_err_y         (req_drive.att_err_y),
		.rate_x            (req_drive.rate_x),
		.rate_y            (req_drive.rate_y),
		.rate_z            (req_drive.rate_z),
		.yaw_rate_ref      (req_drive.yaw_rate_ref),
		.throttle          (req_drive.throttle),
		.done              (done),
		.motor_front_left  (motor_front_left),
		.motor_front_right (motor_front_right),
		.motor_back_left   (motor_back_left),
		.motor_back_right  (motor_back_right),
		.motor_mid_left    (motor_mid_left),
		.motor_mid_right   (motor_mid_right),
		.roll_command      (roll_command),
		.pitch_command     (pitch_command),
		.yaw_command       (yaw_command)
	);

	always #HALF_PERIOD clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// throttle plus scaled mix, cut toward zero, then clamped; low clip wins when crossed
	function automatic logic [15:0] pwm_lane(logic [15:0] thr, longint mix, int frac);
		longint t;
		longint ip;
		t = (longint'(thr) <<< frac) + longint'(m_set.scaling) * mix;
		if (t >= 0)
			ip = t >>> frac;
		else
			ip = -((-t) >>> frac);
		if (ip > longint'(m_set.clip_hi))
			ip = longint'(m_set.clip_hi);
		if (ip < longint'(m_set.clip_lo))
			ip = longint'(m_set.clip_lo);
		return ip[15:0];
	endfunction

	function automatic mix_out_t mixer_predict(sample_t s);
		longint qg;
		longint rg;
		longint zg;
		longint r;
		longint p;
		longint y;
		longint hp;
		longint side;
		longint mid;
		mix_out_t o;
		qg = longint'($signed(m_set.quat_gain));
		rg = longint'($signed(m_set.rate_gain));
		zg = longint'($signed(m_set.yaw_gain));
		// quaternion term Q.22 floors down to Q.16, rate terms are already Q.16
		r = ((qg * longint'($signed(s.att_err_x))) >>> Q22_TO_Q16)
			+ rg * longint'($signed(s.rate_x));
		p = ((qg * longint'($signed(s.att_err_y))) >>> Q22_TO_Q16)
			+ rg * longint'($signed(s.rate_y));
		y = zg * (longint'($signed(s.rate_z)) - longint'($signed(s.yaw_rate_ref)));
		o = '0;
		if (m_set.mode == FRAME_QUAD) begin
			o.pwm[M_FL] = pwm_lane(s.throttle, r + p + y, QUAD_FRAC);
			o.pwm[M_FR] = pwm_lane(s.throttle, -r + p - y, QUAD_FRAC);
			o.pwm[M_BL] = pwm_lane(s.throttle, r - p - y, QUAD_FRAC);
			o.pwm[M_BR] = pwm_lane(s.throttle, -r - p + y, QUAD_FRAC);
		end else begin
			hp = K_HALF * p;
			side = K_134 * r + K_134 * y;
			mid = K_2679 * r - K_2321 * y;
			o.pwm[M_FL] = pwm_lane(s.throttle, hp + side, HEX_FRAC);
			o.pwm[M_FR] = pwm_lane(s.throttle, hp - side, HEX_FRAC);
			o.pwm[M_BL] = pwm_lane(s.throttle, -hp + side, HEX_FRAC);
			o.pwm[M_BR] = pwm_lane(s.throttle, -hp - side, HEX_FRAC);
			o.pwm[M_ML] = pwm_lane(s.throttle, mid, HEX_FRAC);
			o.pwm[M_MR] = pwm_lane(s.throttle, -mid, HEX_FRAC);
		end
		o.roll = r[31:0];
		o.pitch = p[31:0];
		o.yaw = y[31:0];
		return o;
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic string lane_label(int m);
		case (m)
			M_FL: return "motor_front_left";
			M_FR: return "motor_front_right";
			M_BL: return "motor_back_left";
			M_BR: return "motor_back_right";
			M_ML: return "motor_mid_left";
			default: return "motor_mid_right";
		endcase
	endfunction

	task automatic note_miss(input string field, input logic [31:0] want_v,
			input logic [31:0] got_v);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS)
			$display("result %0d: %s expected %h, got %h", res_cnt, field, want_v, got_v);
	endtask

	// everything happens at the rising edge: result check, register shadow, new request
	always @(posedge clk) begin : monitor
		mix_out_t want;
		mix_out_t got;
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout at cycle %0d with %0d results outstanding", cycle_cnt,
				mix_expect_q.size());
			$display("Some tests failed");
			$finish;
		end else if (arst_n) begin
			if (done) begin
				if (mix_expect_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("result at cycle %0d with no request outstanding", cycle_cnt);
				end else begin
					want = mix_expect_q.pop_front();
					res_cnt++;
					got.pwm[M_FL] = motor_front_left;
					got.pwm[M_FR] = motor_front_right;
					got.pwm[M_BL] = motor_back_left;
					got.pwm[M_BR] = motor_back_right;
					got.pwm[M_ML] = motor_mid_left;
					got.pwm[M_MR] = motor_mid_right;
					for (int m = 0; m < NUM_MOTORS; m++) begin
						if (got.pwm[m] !== want.pwm[m])
							note_miss(lane_label(m), 32'(want.pwm[m]), 32'(got.pwm[m]));
					end
					if (roll_command !== want.roll)
						note_miss("roll_command", want.roll, roll_command);
					if (pitch_command !== want.pitch)
						note_miss("pitch_command", want.pitch, pitch_command);
					if (yaw_command !== want.yaw)
						note_miss("yaw_command", want.yaw, yaw_command);
				end
			end
			// writes only land while nothing is in flight
			if (cfg_we) begin
				case (cfg_idx)
					REG_QUAT_GAIN_XY: m_set.quat_gain = cfg_wdata;
					REG_RATE_GAIN_XY: m_set.rate_gain = cfg_wdata;
					REG_RATE_GAIN_Z:  m_set.yaw_gain = cfg_wdata;
					REG_PWM_SCALING:  m_set.scaling = cfg_wdata;
					REG_CLIP_LOW:     m_set.clip_lo = cfg_wdata;
					REG_CLIP_HIGH:    m_set.clip_hi = cfg_wdata;
					REG_FRAME_MODE:   m_set.mode = frame_t'(cfg_wdata[0]);
					default: ;
				endcase
			end
			if (start && !busy) begin
				req_cnt++;
				mix_expect_q.push_back(req_typed ? req_expect : mixer_predict(req_drive));
			end
		end
	end

	// ---------------------------------------------------------------- driving

	// one request: optional idle cycles, then hold it until the block takes it
	task automatic send(input sample_t s, input logic typed, input mix_out_t e);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req_drive <= s;
		req_typed <= typed;
		req_expect <= e;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// stop requesting and let every outstanding result come back
	task automatic idle_wait();
		start <= 1'b0;
		while (mix_expect_q.size() != 0)
			@(negedge clk);
	endtask

	// writes every register; write enable stays up across the burst
	task automatic load_setting(input setting_t c);
		cfg_we <= 1'b1;
		cfg_idx <= REG_QUAT_GAIN_XY;
		cfg_wdata <= c.quat_gain;
		@(negedge clk);
		cfg_idx <= REG_RATE_GAIN_XY;
		cfg_wdata <= c.rate_gain;
		@(negedge clk);
		cfg_idx <= REG_RATE_GAIN_Z;
		cfg_wdata <= c.yaw_gain;
		@(negedge clk);
		cfg_idx <= REG_PWM_SCALING;
		cfg_wdata <= c.scaling;
		@(negedge clk);
		cfg_idx <= REG_CLIP_LOW;
		cfg_wdata <= c.clip_lo;
		@(negedge clk);
		cfg_idx <= REG_CLIP_HIGH;
		cfg_wdata <= c.clip_hi;
		@(negedge clk);
		// upper data bits are don't care for the frame select
		cfg_idx <= REG_FRAME_MODE;
		cfg_wdata <= {15'($urandom), c.mode};
		@(negedge clk);
		// an undecoded index must leave every register alone
		if ($urandom_range(1)) begin
			cfg_idx <= REG_UNUSED;
			cfg_wdata <= 16'($urandom);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		setting_cnt++;
	endtask

	function automatic setting_t mk_set(int qg, int rg, int zg, int sc, int lo, int hi,
			frame_t md);
		setting_t c;
		c.quat_gain = 16'(qg);
		c.rate_gain = 16'(rg);
		c.yaw_gain = 16'(zg);
		c.scaling = 16'(sc);
		c.clip_lo = 16'(lo);
		c.clip_hi = 16'(hi);
		c.mode = md;
		return c;
	endfunction

	function automatic dir_row_t mk_row(int set_id, bit typed, int ax, int ay, int wx,
			int wy, int wz, int wr, int thr);
		dir_row_t row;
		row.set_id = 3'(set_id);
		row.typed = typed;
		row.s.att_err_x = 16'(ax);
		row.s.att_err_y = 16'(ay);
		row.s.rate_x = 16'(wx);
		row.s.rate_y = 16'(wy);
		row.s.rate_z = 16'(wz);
		row.s.yaw_rate_ref = 16'(wr);
		row.s.throttle = 16'(thr);
		return row;
	endfunction

	// ---------------------------------------------------------------- random content

	// mostly legal quaternion parts, with the full 16-bit range now and then
	function automatic logic [15:0] rand_att();
		int c;
		c = $urandom_range(99);
		if (c < 10)
			return 16'($urandom);
		if (c < 20)
			return 16'($urandom_range(2) * 16384 - 16384);
		return 16'($urandom_range(32768) - 16384);
	endfunction

	function automatic logic [15:0] rand_rate();
		int c;
		c = $urandom_range(99);
		if (c < 12) begin
			case ($urandom_range(3))
				0: return 16'h8000;
				1: return 16'h7fff;
				2: return 16'h0000;
				default: return 16'hffff;
			endcase
		end
		return 16'($urandom);
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		int c;
		s.att_err_x = rand_att();
		s.att_err_y = rand_att();
		s.rate_x = rand_rate();
		s.rate_y = rand_rate();
		s.rate_z = rand_rate();
		s.yaw_rate_ref = rand_rate();
		c = $urandom_range(99);
		if (c < 10)
			s.throttle = $urandom_range(1) ? 16'hffff : 16'h0000;
		else
			s.throttle = 16'($urandom);
		return s;
	endfunction

	// gains lean to small values so the motors are not always pinned to a clip
	function automatic logic [15:0] rand_gain();
		int c;
		c = $urandom_range(99);
		if (c < 10)
			return 16'h8000;
		if (c < 20)
			return 16'h7fff;
		if (c < 25)
			return 16'h0000;
		if (c < 60)
			return 16'($urandom_range(2048) - 1024);
		return 16'($urandom);
	endfunction

	function automatic setting_t rand_setting();
		setting_t c;
		int pick;
		c.quat_gain = rand_gain();
		c.rate_gain = rand_gain();
		c.yaw_gain = rand_gain();
		pick = $urandom_range(99);
		if (pick < 20)
			c.scaling = 16'd256;
		else if (pick < 25)
			c.scaling = 16'd0;
		else if (pick < 30)
			c.scaling = 16'hffff;
		else if (pick < 60)
			c.scaling = 16'($urandom_range(1024));
		else
			c.scaling = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 15) begin
			// crossed window
			c.clip_hi = 16'($urandom_range(40000));
			c.clip_lo = 16'(c.clip_hi + 1 + $urandom_range(65534 - c.clip_hi));
		end else if (pick < 22) begin
			c.clip_lo = 16'($urandom);
			c.clip_hi = c.clip_lo;
		end else if (pick < 32) begin
			c.clip_lo = 16'h0000;
			c.clip_hi = 16'hffff;
		end else begin
			c.clip_lo = 16'($urandom_range(20000));
			c.clip_hi = 16'(c.clip_lo + $urandom_range(65535 - c.clip_lo));
		end
		c.mode = frame_t'($urandom_range(1));
		return c;
	endfunction

	// ---------------------------------------------------------------- sequence

	initial begin
		int cur_set;
		int rand_sent;
		int phase;
		int n;
		mix_out_t typed_exp;

		// every input known from time zero, reset asserted once
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		start = 1'b0;
		req_drive = '0;
		req_typed = 1'b0;
		req_expect = '0;
		m_set = mk_set(0, 0, 0, 256, 0, 65535, FRAME_QUAD);

		// settings of the directed part; entry zero is the reset state and is not written
		dir_set[0] = mk_set(0, 0, 0, 256, 0, 65535, FRAME_QUAD);
		dir_set[1] = mk_set(32767, 32767, 32767, 256, 0, 65535, FRAME_QUAD);
		dir_set[2] = mk_set(-32768, -32768, -32768, 65535, 0, 65535, FRAME_HEX);
		dir_set[3] = mk_set(300, -77, 1234, 256, 40000, 1000, FRAME_HEX);
		dir_set[4] = mk_set(-3, 5, -7, 3, 1000, 2000, FRAME_QUAD);
		dir_set[5] = mk_set(256, 256, 256, 0, 0, 65535, FRAME_HEX);

		// reset state: zero gains and unit scaling, corner motors follow throttle
		dir_tab[0] = mk_row(0, 1, 0, 0, 0, 0, 0, 0, 0);
		dir_tab[1] = mk_row(0, 1, 16384, -16384, 32767, -32768, 32767, -32768, 65535);
		dir_tab[2] = mk_row(0, 1, -32768, 32767, 1234, -4321, 777, -555, 23130);
		// largest positive gains, quad
		dir_tab[3] = mk_row(1, 0, 16384, -16384, 32767, -32768, 32767, -32768, 32768);
		dir_tab[4] = mk_row(1, 0, -16384, 16384, -32768, 32767, -32768, 32767, 0);
		dir_tab[5] = mk_row(1, 0, -32768, 32767, 0, 0, 0, 0, 1000);
		dir_tab[6] = mk_row(1, 0, 100, -100, 256, -256, 512, 512, 65535);
		// most negative gains, full scaling, hex
		dir_tab[7] = mk_row(2, 0, 16384, -16384, 32767, -32768, 32767, -32768, 32768);
		dir_tab[8] = mk_row(2, 0, -16384, 16384, -32768, 32767, -32768, 32767, 0);
		dir_tab[9] = mk_row(2, 0, -32768, -32768, -32768, -32768, -32768, 32767, 65535);
		dir_tab[10] = mk_row(2, 0, 1, -1, 1, -1, 1, 0, 30000);
		dir_tab[11] = mk_row(2, 0, 0, 0, 0, 0, 0, 0, 30000);
		// crossed clip window: low limit wins on every motor
		dir_tab[12] = mk_row(3, 0, 16384, 16384, 32767, 32767, -32768, 32767, 65535);
		dir_tab[13] = mk_row(3, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_tab[14] = mk_row(3, 0, -9000, 4000, -1200, 300, 50, -60, 1500);
		// odd small gains: floor of the quaternion term, cut toward zero, narrow window
		dir_tab[15] = mk_row(4, 0, 1, -1, -1, 1, -3, 3, 1500);
		dir_tab[16] = mk_row(4, 0, -16384, 16384, 0, 0, 0, 0, 999);
		dir_tab[17] = mk_row(4, 0, -1, 1, 2, -2, 0, 0, 2001);
		dir_tab[18] = mk_row(4, 0, -16384, -16384, -32768, -32768, 32767, -32768, 0);
		// zero scaling: motors equal throttle, commands still live
		dir_tab[19] = mk_row(5, 0, 5000, -7000, 2000, -3000, 400, 100, 12345);
		dir_tab[20] = mk_row(5, 0, -16384, 16384, -32768, 32767, 32767, -32768, 65535);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part
		cur_set = 0;
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (int'(dir_tab[i].set_id) != cur_set) begin
				cur_set = dir_tab[i].set_id;
				idle_wait();
				load_setting(dir_set[cur_set]);
			end
			typed_exp = '0;
			for (int m = M_FL; m <= M_BR; m++)
				typed_exp.pwm[m] = dir_tab[i].s.throttle;
			send(dir_tab[i].s, dir_tab[i].typed, typed_exp);
		end

		// random part: a fresh setting per phase, some phases without idle cycles
		rand_sent = 0;
		phase = 0;
		while (rand_sent < RAND_ITEMS) begin
			idle_wait();
			load_setting(rand_setting());
			idle_pct = (phase % 5 == 3) ? 0 : IDLE_PCT;
			n = $urandom_range(200, 80);
			for (int k = 0; k < n && rand_sent < RAND_ITEMS; k++) begin
				send(rand_sample(), 1'b0, '0);
				rand_sent++;
			end
			phase++;
		end

		// drain, then give the pipeline time to show any stray result
		idle_wait();
		repeat (PIPE_DEPTH + 4) @(negedge clk);

		$display("%0d requests, %0d results checked, %0d mismatches", req_cnt, res_cnt,
			err_cnt);
		$display("%0d register settings: quad and hex, gain and scaling extremes, crossed clips",
			setting_cnt + 1);
		if (err_cnt == 0 && mix_expect_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
design/arcmm_pkg.sv
design/attitude_rate_control_motor_mixer_core.sv
dv/attitude_rate_control_motor_mixer_core_tb.sv
